### rtl/core/nsfc_pkg.sv
// Package for the NMEA sentence framer and checksum checker.
// Holds character codes, result codes and the classified word type
// shared by the front, back and top modules.
`default_nettype none

package nsfc_pkg;

  localparam int MAX_FIELDS_DEF = 64;
  localparam int LEN_W          = 11;
  localparam int FIELD_W        = 7;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd256;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_Q      = 8'h51;

  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_RMC = 24'h524D43;
  localparam logic [23:0] TYPE_GSV = 24'h475356;
  localparam logic [23:0] TYPE_GSA = 24'h475341;
  localparam logic [23:0] TYPE_SXT = 24'h535854;
  localparam logic [23:0] TYPE_VTG = 24'h565447;
  localparam logic [23:0] TYPE_YMR = 24'h594D52;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_GGA     = 3'd1;
  localparam logic [2:0] KIND_RMC     = 3'd2;
  localparam logic [2:0] KIND_GSV     = 3'd3;
  localparam logic [2:0] KIND_GSA     = 3'd4;
  localparam logic [2:0] KIND_SXT     = 3'd5;
  localparam logic [2:0] KIND_VTG     = 3'd6;
  localparam logic [2:0] KIND_YMR     = 3'd7;

  localparam logic [2:0] TALK_NONE = 3'd0;
  localparam logic [2:0] TALK_P    = 3'd1;
  localparam logic [2:0] TALK_L    = 3'd2;
  localparam logic [2:0] TALK_A    = 3'd3;
  localparam logic [2:0] TALK_B    = 3'd4;
  localparam logic [2:0] TALK_Q    = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NO_FIELDS = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_sync_letter;
    logic       is_field_end;
    logic       is_star;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [2:0] talker;
  } item_t;

endpackage

`default_nettype wire

### rtl/core/nsfc_front.sv
// Front end: classifies each received byte and queues it for the back end.
// Uses nsfc_pkg for character codes and the item_t word type.
`default_nettype none

module nsfc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_data_byte,
  output logic                q_valid,
  output nsfc_pkg::item_t     q_item,
  input  wire logic           q_pop
);

  nsfc_pkg::item_t                   cls;
  nsfc_pkg::item_t                   mem_r [nsfc_pkg::QUEUE_DEPTH];
  logic [nsfc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [nsfc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [nsfc_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              push;

  always_comb begin
    cls                = '0;
    cls.data           = in_data_byte;
    cls.is_sync_letter = (in_data_byte == nsfc_pkg::CH_G) || (in_data_byte == nsfc_pkg::CH_V);
    cls.is_star        = (in_data_byte == nsfc_pkg::CH_STAR);
    cls.is_field_end   = cls.is_star || (in_data_byte == nsfc_pkg::CH_COMMA);
    cls.is_lf          = (in_data_byte == nsfc_pkg::CH_LF);
    if (in_data_byte >= 8'h30 && in_data_byte <= 8'h39) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(in_data_byte - 8'h30);
    end else if (in_data_byte >= 8'h41 && in_data_byte <= 8'h46) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(in_data_byte - 8'h37);
    end else if (in_data_byte >= 8'h61 && in_data_byte <= 8'h66) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(in_data_byte - 8'h57);
    end
    unique case (in_data_byte)
      nsfc_pkg::CH_P: cls.talker = nsfc_pkg::TALK_P;
      nsfc_pkg::CH_L: cls.talker = nsfc_pkg::TALK_L;
      nsfc_pkg::CH_A: cls.talker = nsfc_pkg::TALK_A;
      nsfc_pkg::CH_B: cls.talker = nsfc_pkg::TALK_B;
      nsfc_pkg::CH_Q: cls.talker = nsfc_pkg::TALK_Q;
      default:        cls.talker = nsfc_pkg::TALK_NONE;
    endcase
  end

  assign in_ready = (count_r != nsfc_pkg::QCNT_W'(nsfc_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == nsfc_pkg::QPTR_W'(nsfc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == nsfc_pkg::QPTR_W'(nsfc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nsfc_pkg::QCNT_W'(nsfc_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == nsfc_pkg::QCNT_W'(nsfc_pkg::QUEUE_DEPTH) |-> !push)
    else $error("word pushed into full queue");

endmodule

`default_nettype wire

### rtl/core/nsfc_back.sv
// Back end: sentence framing, checksum, field count and result register.
// Takes classified words from nsfc_front; uses nsfc_pkg codes.
`default_nettype none

module nsfc_back #(
  parameter int MAX_FIELDS = nsfc_pkg::MAX_FIELDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire nsfc_pkg::item_t              q_item,
  output logic                              q_pop,
  input  wire logic                         cfg_wr_en,
  input  wire logic [nsfc_pkg::LEN_W-1:0]   cfg_wr_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [2:0]                        out_sentence_kind,
  output logic [2:0]                        out_talker_system,
  output logic [nsfc_pkg::LEN_W-1:0]        out_sentence_length,
  output logic [nsfc_pkg::FIELD_W-1:0]      out_field_count,
  output logic [7:0]                        out_computed_sum,
  output logic [7:0]                        out_received_sum
);

  function automatic logic [2:0] kind_of(input logic [23:0] t);
    unique case (t)
      nsfc_pkg::TYPE_GGA: kind_of = nsfc_pkg::KIND_GGA;
      nsfc_pkg::TYPE_RMC: kind_of = nsfc_pkg::KIND_RMC;
      nsfc_pkg::TYPE_GSV: kind_of = nsfc_pkg::KIND_GSV;
      nsfc_pkg::TYPE_GSA: kind_of = nsfc_pkg::KIND_GSA;
      nsfc_pkg::TYPE_SXT: kind_of = nsfc_pkg::KIND_SXT;
      nsfc_pkg::TYPE_VTG: kind_of = nsfc_pkg::KIND_VTG;
      nsfc_pkg::TYPE_YMR: kind_of = nsfc_pkg::KIND_YMR;
      default:            kind_of = nsfc_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  logic [nsfc_pkg::LEN_W-1:0]   max_len_r;
  logic [nsfc_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic                         prev_dollar_r, prev_dollar_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic                         star_r, star_nxt;
  logic [7:0]                   hex_r, hex_nxt;
  logic                         stop_r, stop_nxt;
  logic [23:0]                  type_r, type_nxt;
  logic [2:0]                   talker_r, talker_nxt;
  logic [nsfc_pkg::FIELD_W-1:0] fields_r, fields_nxt;

  logic                         emit;
  nsfc_pkg::status_t            emit_status;
  logic [nsfc_pkg::LEN_W-1:0]   emit_len;
  logic [7:0]                   rcv_sum;
  logic                         out_valid_r, out_valid_nxt;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    cnt_nxt         = cnt_r;
    prev_dollar_nxt = prev_dollar_r;
    xor_nxt         = xor_r;
    star_nxt        = star_r;
    hex_nxt         = hex_r;
    stop_nxt        = stop_r;
    type_nxt        = type_r;
    talker_nxt      = talker_r;
    fields_nxt      = fields_r;
    emit            = 1'b0;
    emit_status     = nsfc_pkg::ST_OK;
    emit_len        = cnt_r;
    rcv_sum         = 8'd0;
    if (q_pop) begin
      if (cnt_r == '0) begin
        prev_dollar_nxt = (q_item.data == nsfc_pkg::CH_DOLLAR);
        if (prev_dollar_r && q_item.is_sync_letter) begin
          cnt_nxt    = nsfc_pkg::LEN_W'(2);
          xor_nxt    = q_item.data;
          star_nxt   = 1'b0;
          hex_nxt    = 8'd0;
          stop_nxt   = 1'b0;
          type_nxt   = 24'd0;
          talker_nxt = nsfc_pkg::TALK_NONE;
          fields_nxt = '0;
        end
      end else if (cnt_r >= max_len_r) begin
        emit        = 1'b1;
        emit_status = nsfc_pkg::ST_OVERFLOW;
        emit_len    = cnt_r;
        cnt_nxt     = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r)
          nsfc_pkg::LEN_W'(2): talker_nxt       = q_item.talker;
          nsfc_pkg::LEN_W'(3): type_nxt[23:16]  = q_item.data;
          nsfc_pkg::LEN_W'(4): type_nxt[15:8]   = q_item.data;
          nsfc_pkg::LEN_W'(5): type_nxt[7:0]    = q_item.data;
          default: ;
        endcase
        if (q_item.is_field_end && fields_r < nsfc_pkg::FIELD_W'(MAX_FIELDS)) begin
          fields_nxt = fields_r + 1'b1;
        end
        if (!star_r) begin
          if (q_item.is_star) begin
            star_nxt = 1'b1;
          end else begin
            xor_nxt = xor_r ^ q_item.data;
          end
        end else if (!stop_r) begin
          if (q_item.is_hex) begin
            hex_nxt = {hex_r[3:0], q_item.hex_val};
          end else begin
            stop_nxt = 1'b1;
          end
        end
        if (q_item.is_lf) begin
          emit     = 1'b1;
          emit_len = cnt_r + 1'b1;
          cnt_nxt  = '0;
          rcv_sum  = star_nxt ? hex_nxt : 8'd0;
          if (xor_nxt != rcv_sum) begin
            emit_status = nsfc_pkg::ST_MISMATCH;
          end else if (fields_nxt == '0) begin
            emit_status = nsfc_pkg::ST_NO_FIELDS;
          end else begin
            emit_status = nsfc_pkg::ST_OK;
          end
        end
      end
    end
    if (emit_status == nsfc_pkg::ST_OVERFLOW) begin
      rcv_sum = star_nxt ? hex_nxt : 8'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r     <= nsfc_pkg::MAX_LEN_RESET;
      cnt_r         <= '0;
      prev_dollar_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      cnt_r         <= cnt_nxt;
      prev_dollar_r <= prev_dollar_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xor_r    <= xor_nxt;
    star_r   <= star_nxt;
    hex_r    <= hex_nxt;
    stop_r   <= stop_nxt;
    type_r   <= type_nxt;
    talker_r <= talker_nxt;
    fields_r <= fields_nxt;
    if (emit) begin
      out_status          <= emit_status;
      out_sentence_kind   <= kind_of(type_nxt);
      out_talker_system   <= talker_nxt;
      out_sentence_length <= emit_len;
      out_field_count     <= fields_nxt;
      out_computed_sum    <= xor_nxt;
      out_received_sum    <= rcv_sum;
    end
  end

  assign out_valid = out_valid_r;

  a_cnt_never_one: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != nsfc_pkg::LEN_W'(1))
    else $error("byte count skipped sync pair");

  a_closed_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status != nsfc_pkg::ST_OVERFLOW |-> out_sentence_length >= 3)
    else $error("closed sentence shorter than three bytes");

  a_fields_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_field_count <= nsfc_pkg::FIELD_W'(MAX_FIELDS))
    else $error("field count above limit");

endmodule

`default_nettype wire

### rtl/core/nmea_sentence_framer_checker.sv
// NMEA sentence framer and checksum checker, top level.
// Throughput: one byte per cycle unless stalled; a 2-entry queue splits classify and framing.
// A result becomes valid in the cycle after the line feed (or overflow) word is taken.
// Framing state advances one byte per cycle; the result register stalls it on backpressure.
// Reset (rst_n, synchronous, active low): hunting for sync, limit 256, queue and result empty.
`default_nettype none

module nmea_sentence_framer_checker #(
  parameter int MAX_FIELDS = nsfc_pkg::MAX_FIELDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_data_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [2:0]                        out_sentence_kind,
  output logic [2:0]                        out_talker_system,
  output logic [nsfc_pkg::LEN_W-1:0]        out_sentence_length,
  output logic [nsfc_pkg::FIELD_W-1:0]      out_field_count,
  output logic [7:0]                        out_computed_sum,
  output logic [7:0]                        out_received_sum,
  input  wire logic                         cfg_wr_en,
  input  wire logic [nsfc_pkg::LEN_W-1:0]   cfg_wr_data
);

  logic            q_valid;
  logic            q_pop;
  nsfc_pkg::item_t q_item;

  nsfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  nsfc_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_sentence_kind   (out_sentence_kind),
    .out_talker_system   (out_talker_system),
    .out_sentence_length (out_sentence_length),
    .out_field_count     (out_field_count),
    .out_computed_sum    (out_computed_sum),
    .out_received_sum    (out_received_sum)
  );

endmodule

`default_nettype wire
